### rtl/core/swseq_pkg.sv
// package for the shadowed register write sequencer
// types, register codes and constants shared by all rtl/core modules
`timescale 1ns / 1ps

package swseq_pkg;

  localparam int MIRROR_DEPTH = 24;
  localparam int AW = 5;
  localparam int DW = 8;
  localparam int IDX_W = $clog2(MIRROR_DEPTH);
  localparam int MAX_WRITES = 5;
  localparam int MAX_UPD = 3;
  localparam int CNT_W = $clog2(MAX_WRITES + 1);
  localparam int PTR_W = $clog2(MAX_WRITES);
  localparam int UCNT_W = $clog2(MAX_UPD + 1);
  localparam int TDATA_W = ((AW + DW + 7) / 8) * 8;

  localparam logic [AW-1:0] REG_PH0 = 5'h03;
  localparam logic [AW-1:0] REG_PH1 = 5'h07;
  localparam logic [AW-1:0] FRAME_REG = 5'h17;

  localparam logic [DW-1:0] LOW_DOWN_DATA = 8'h00;
  localparam logic [DW-1:0] LOW_UP_DATA = 8'hFF;
  localparam logic [DW-1:0] SWP_DOWN_DATA = 8'h8F;
  localparam logic [DW-1:0] SWP_UP_DATA = 8'h87;
  localparam logic [DW-1:0] FRAME_DATA = 8'hC0;
  localparam logic [DW-1:0] SWP_REST_DATA = 8'h0F;

  typedef enum logic {
    OP_IF_CHANGED = 1'b0,
    OP_FORCED     = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [AW-1:0] addr;
    logic [DW-1:0] data;
  } wr_t;

  typedef struct packed {
    logic en;
    wr_t  w;
  } mwr_t;

  typedef struct packed {
    logic [MAX_UPD-1:0] vld;
    wr_t [MAX_UPD-1:0]  ent;
  } pend_t;

  typedef struct packed {
    logic                  vld;
    logic [CNT_W-1:0]      n;
    wr_t [MAX_WRITES-1:0]  wr;
    logic [UCNT_W-1:0]     un;
    wr_t [MAX_UPD-1:0]     upd;
  } plan_t;

endpackage

### rtl/core/swseq_mirror.sv
// register mirror: synchronous memory, two read ports, one write port
// per-entry valid bits give the all-zero reset; depends on swseq_pkg
`timescale 1ns / 1ps

module swseq_mirror (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [swseq_pkg::IDX_W-1:0] rd_a_addr,
  input  logic [swseq_pkg::IDX_W-1:0] rd_b_addr,
  output logic [swseq_pkg::DW-1:0]    rd_a_data,
  output logic [swseq_pkg::DW-1:0]    rd_b_data,
  input  swseq_pkg::mwr_t             mwr
);
  import swseq_pkg::*;

  logic [DW-1:0]           mem_r [MIRROR_DEPTH];
  logic [MIRROR_DEPTH-1:0] vld_r;
  logic [DW-1:0]           rd_a_r;
  logic [DW-1:0]           rd_b_r;
  logic [IDX_W-1:0]        wr_idx;

  assign wr_idx = mwr.w.addr[IDX_W-1:0];
  assign rd_a_data = rd_a_r;
  assign rd_b_data = rd_b_r;

  always_ff @(posedge clk) begin
    if (mwr.en) begin
      mem_r[wr_idx] <= mwr.w.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mwr.en) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

  // write-through on a same-cycle address match
  always_ff @(posedge clk) begin
    if (mwr.en && wr_idx == rd_a_addr) begin
      rd_a_r <= mwr.w.data;
    end else begin
      rd_a_r <= vld_r[rd_a_addr] ? mem_r[rd_a_addr] : '0;
    end
    if (mwr.en && wr_idx == rd_b_addr) begin
      rd_b_r <= mwr.w.data;
    end else begin
      rd_b_r <= vld_r[rd_b_addr] ? mem_r[rd_b_addr] : '0;
    end
  end

endmodule

### rtl/core/swseq_plan.sv
// request stage: mirror read, forwarding from pending updates, write planning
// depends on swseq_pkg; feeds swseq_emit
`timescale 1ns / 1ps

module swseq_plan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [0:0]                  in_tuser,
  input  logic [swseq_pkg::TDATA_W-1:0] in_tdata,
  output logic [swseq_pkg::IDX_W-1:0] rd_a_addr,
  output logic [swseq_pkg::IDX_W-1:0] rd_b_addr,
  input  logic [swseq_pkg::DW-1:0]    rd_a_data,
  input  logic [swseq_pkg::DW-1:0]    rd_b_data,
  input  swseq_pkg::pend_t            pend,
  input  logic                        seq_free,
  output swseq_pkg::plan_t            plan
);
  import swseq_pkg::*;

  logic          s1_v_r;
  opcode_t       s1_op_r;
  logic [AW-1:0] s1_idx_r;
  logic [DW-1:0] s1_val_r;

  logic          acc;
  logic          s1_adv;
  logic [AW-1:0] in_idx;
  logic [AW-1:0] a_idx;
  logic [AW-1:0] b_idx;
  logic [AW-1:0] s1_low_idx;
  logic [DW-1:0] old_val;
  logic [DW-1:0] low_keep;
  logic          in_rng;
  logic          forced;
  logic          emit_any;
  logic          down;
  logic          up;
  logic          sweep;
  logic [AW-1:0] base;
  logic [AW-1:0] low_reg;
  logic [AW-1:0] swp_reg;

  function automatic logic in_mirror(input logic [AW-1:0] x);
    in_mirror = {1'b0, x} < (AW + 1)'(MIRROR_DEPTH);
  endfunction

  function automatic logic [DW-1:0] fwd(input logic [DW-1:0] rd, input logic [AW-1:0] a,
                                        input pend_t p);
    logic [DW-1:0] r;
    r = rd;
    for (int j = 0; j < MAX_UPD; j++) begin
      if (p.vld[j] && p.ent[j].addr == a) begin
        r = p.ent[j].data;
      end
    end
    fwd = r;
  endfunction

  assign in_idx = in_tdata[AW-1:0];
  assign acc = in_tvalid && in_tready;
  assign in_tready = !s1_v_r || s1_adv;

  assign a_idx = acc ? in_idx : s1_idx_r;
  assign b_idx = a_idx - AW'(1);
  assign rd_a_addr = in_mirror(a_idx) ? a_idx[IDX_W-1:0] : '0;
  assign rd_b_addr = in_mirror(b_idx) ? b_idx[IDX_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_op_r  <= opcode_t'(in_tuser[0]);
      s1_idx_r <= in_idx;
      s1_val_r <= in_tdata[AW +: DW];
    end
  end

  assign s1_low_idx = s1_idx_r - AW'(1);
  assign old_val  = fwd(rd_a_data, s1_idx_r, pend);
  assign low_keep = fwd(rd_b_data, s1_low_idx, pend);

  assign in_rng   = in_mirror(s1_idx_r);
  assign forced   = s1_op_r == OP_FORCED;
  assign emit_any = in_rng && (forced || old_val != s1_val_r);
  assign down = {1'b0, old_val[2:0]} == {1'b0, s1_val_r[2:0]} + 4'd1;
  assign up   = {1'b0, s1_val_r[2:0]} == {1'b0, old_val[2:0]} + 4'd1;
  assign sweep = !forced && (s1_idx_r == REG_PH0 || s1_idx_r == REG_PH1) && (down || up);

  assign base    = s1_idx_r - REG_PH0;
  assign low_reg = base + AW'(2);
  assign swp_reg = base + AW'(1);

  assign s1_adv = s1_v_r && (!emit_any || seq_free);

  always_comb begin
    plan = '0;
    plan.vld = s1_v_r && emit_any && seq_free;
    if (sweep) begin
      plan.n = CNT_W'(5);
      plan.wr[0] = '{addr: low_reg, data: down ? LOW_DOWN_DATA : LOW_UP_DATA};
      plan.wr[1] = '{addr: swp_reg, data: down ? SWP_DOWN_DATA : SWP_UP_DATA};
      plan.wr[2] = '{addr: FRAME_REG, data: FRAME_DATA};
      plan.wr[3] = '{addr: swp_reg, data: SWP_REST_DATA};
      plan.wr[4] = '{addr: low_reg, data: low_keep};
      plan.un = UCNT_W'(3);
      plan.upd[0] = '{addr: s1_idx_r, data: s1_val_r};
      plan.upd[1] = '{addr: swp_reg, data: SWP_REST_DATA};
      plan.upd[2] = '{addr: FRAME_REG, data: FRAME_DATA};
    end else begin
      plan.n = CNT_W'(1);
      plan.wr[0] = '{addr: s1_idx_r, data: s1_val_r};
      plan.un = UCNT_W'(1);
      plan.upd[0] = '{addr: s1_idx_r, data: s1_val_r};
    end
  end

endmodule

### rtl/core/swseq_emit.sv
// write sequencer: holds the planned writes, emits one per cycle while out_tready is high,
// and commits mirror updates one per cycle; depends on swseq_pkg
`timescale 1ns / 1ps

module swseq_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  swseq_pkg::plan_t              plan,
  output logic                          seq_free,
  output swseq_pkg::pend_t              pend,
  output swseq_pkg::mwr_t               mwr,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic                          out_tlast,
  output logic [swseq_pkg::TDATA_W-1:0] out_tdata
);
  import swseq_pkg::*;

  wr_t [MAX_WRITES-1:0] lst_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [PTR_W-1:0]     ptr_r;
  logic                 v_r;
  wr_t [MAX_UPD-1:0]    upd_r;
  logic [UCNT_W-1:0]    ucnt_r;
  logic [UCNT_W-1:0]    uptr_r;

  logic                 last;
  logic                 done;
  wr_t                  cur;

  assign cur  = lst_r[ptr_r];
  assign last = {1'b0, ptr_r} == {1'b0, cnt_r} - (CNT_W + 1)'(1);
  assign done = v_r && out_tready && last;
  assign seq_free = !v_r || done;

  assign out_tvalid = v_r;
  assign out_tlast  = last;
  assign out_tdata  = {{(TDATA_W - AW - DW){1'b0}}, cur.data, cur.addr};

  always_comb begin
    mwr = '0;
    mwr.en = uptr_r < ucnt_r;
    if (mwr.en) begin
      mwr.w = upd_r[uptr_r];
    end
  end

  always_comb begin
    pend.ent = upd_r;
    for (int j = 0; j < MAX_UPD; j++) begin
      pend.vld[j] = (UCNT_W'(j) >= uptr_r) && (UCNT_W'(j) < ucnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= 1'b0;
      cnt_r  <= '0;
      ptr_r  <= '0;
      ucnt_r <= '0;
      uptr_r <= '0;
    end else if (plan.vld) begin
      v_r    <= 1'b1;
      cnt_r  <= plan.n;
      ptr_r  <= '0;
      ucnt_r <= plan.un;
      uptr_r <= '0;
    end else begin
      if (v_r && out_tready) begin
        if (last) begin
          v_r <= 1'b0;
        end else begin
          ptr_r <= ptr_r + PTR_W'(1);
        end
      end
      if (mwr.en) begin
        uptr_r <= uptr_r + UCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (plan.vld) begin
      lst_r <= plan.wr;
      upd_r <= plan.upd;
    end
  end

endmodule

### rtl/core/shadowed_register_write_sequencer.sv
// top level of the shadowed register write sequencer
// instantiates swseq_mirror, swseq_plan and swseq_emit; depends on swseq_pkg
//
//   channel | direction | handshake            | contents
//   in_     | request   | in_tvalid/in_tready  | tuser opcode, tdata index and value
//   out_    | write     | out_tvalid/out_tready| tdata address and data, tlast end
//
// a request is decided in swseq_plan; its first write shows the cycle after planning
// output rate is one write per cycle while out_tready is high; a sweep gives five writes
// requests giving no write retire without waiting for the sequencer; the mirror's
// single write port commits up to three updates per request, one per cycle
// reset clears the mirror valid bits at once, no clearing pass
// an out_ stall holds the current write; in_ keeps taking one request ahead
`timescale 1ns / 1ps

module shadowed_register_write_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [0:0]                    in_tuser,  // opcode
  input  logic [swseq_pkg::TDATA_W-1:0] in_tdata,  // reg_index, new_value, zero pad
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic                          out_tlast,  // last_write
  output logic [swseq_pkg::TDATA_W-1:0] out_tdata   // write_address, write_data, zero pad
);
  import swseq_pkg::*;

  logic [IDX_W-1:0] rd_a_addr;
  logic [IDX_W-1:0] rd_b_addr;
  logic [DW-1:0]    rd_a_data;
  logic [DW-1:0]    rd_b_data;
  mwr_t             mwr;
  pend_t            pend;
  plan_t            plan;
  logic             seq_free;

  swseq_mirror u_mirror (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data),
    .mwr       (mwr)
  );

  swseq_plan u_plan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data),
    .pend      (pend),
    .seq_free  (seq_free),
    .plan      (plan)
  );

  swseq_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .plan       (plan),
    .seq_free   (seq_free),
    .pend       (pend),
    .mwr        (mwr),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .out_tdata  (out_tdata)
  );

endmodule

### test/shadowed_register_write_sequencer_tb.sv
// testbench for shadowed_register_write_sequencer: directed and random register requests,
// writes checked against a mirror-based predictor of the expected chip writes
// depends on swseq_pkg and the rtl/core sources
`timescale 1ns / 1ps

module shadowed_register_write_sequencer_tb;
  import swseq_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 8;
  localparam int RANDOM_ITEMS = 320;
  localparam int CALM_ITEMS = 50;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    opcode_t       op;
    logic [AW-1:0] idx;
    logic [DW-1:0] val;
  } req_t;

  typedef struct packed {
    logic [AW-1:0] addr;
    logic [DW-1:0] data;
    logic          last;
  } chip_write_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [0:0]           in_tuser = '0;  // opcode
  logic [TDATA_W-1:0]   in_tdata = '0;  // reg_index, new_value, zero pad
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic                 out_tlast;      // last_write
  logic [TDATA_W-1:0]   out_tdata;      // write_address, write_data, zero pad

  req_t        pending_reqs[$];
  chip_write_t expected_writes[$];
  logic [DW-1:0] chip_regs[32];
  logic [DW-1:0] gen_hi[2];

  int cycle_count = 0;
  int mismatches = 0;
  int unexpected = 0;
  int writes_checked = 0;
  int sweeps = 0;
  int plain_writes = 0;
  int skipped = 0;
  int ignored = 0;
  int accepted = 0;

  shadowed_register_write_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tlast (out_tlast),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #(HALF_PERIOD);
    clk = 1'b0;
    #(HALF_PERIOD);
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  task automatic push_write(input logic [AW-1:0] addr, input logic [DW-1:0] data,
                            input logic last);
    chip_write_t w;
    w.addr = addr;
    w.data = data;
    w.last = last;
    expected_writes.push_back(w);
    chip_regs[addr] = data;
  endtask

  task automatic predict_writes(input req_t r);
    logic [DW-1:0] prev;
    logic [DW-1:0] low_keep;
    int lo_old;
    int lo_new;
    logic step_dn;
    logic step_up;
    logic [AW-1:0] low_reg;
    logic [AW-1:0] sweep_reg;
    accepted++;
    if (int'(r.idx) >= MIRROR_DEPTH) begin
      ignored++;
      return;
    end
    if (r.op == OP_FORCED) begin
      plain_writes++;
      push_write(r.idx, r.val, 1'b1);
      return;
    end
    prev = chip_regs[r.idx];
    if (prev == r.val) begin
      skipped++;
      return;
    end
    lo_old = int'(prev[2:0]);
    lo_new = int'(r.val[2:0]);
    step_dn = (lo_old == lo_new + 1);
    step_up = (lo_new == lo_old + 1);
    if ((r.idx == REG_PH0 || r.idx == REG_PH1) && (step_dn || step_up)) begin
      sweeps++;
      low_reg = r.idx - 5'd1;
      sweep_reg = r.idx - 5'd2;
      low_keep = chip_regs[low_reg];
      push_write(low_reg, step_dn ? LOW_DOWN_DATA : LOW_UP_DATA, 1'b0);
      push_write(sweep_reg, step_dn ? SWP_DOWN_DATA : SWP_UP_DATA, 1'b0);
      push_write(FRAME_REG, FRAME_DATA, 1'b0);
      push_write(sweep_reg, SWP_REST_DATA, 1'b0);
      push_write(low_reg, low_keep, 1'b1);
      chip_regs[r.idx] = r.val;
    end else begin
      plain_writes++;
      push_write(r.idx, r.val, 1'b1);
    end
  endtask

  task automatic check_write(input logic [AW-1:0] addr, input logic [DW-1:0] data,
                             input logic last);
    chip_write_t w;
    writes_checked++;
    if (expected_writes.size() == 0) begin
      unexpected++;
      if (mismatches + unexpected <= REPORT_MAX)
        $display("unexpected write: addr %02h data %02h last %0b", addr, data, last);
      return;
    end
    w = expected_writes.pop_front();
    if (w.addr !== addr || w.data !== data || w.last !== last) begin
      mismatches++;
      if (mismatches + unexpected <= REPORT_MAX)
        $display("write mismatch: expected addr %02h data %02h last %0b, got %02h %02h %0b",
                 w.addr, w.data, w.last, addr, data, last);
    end
  endtask

  // request driver
  req_t cur_req;
  int   gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tuser <= '0;
      in_tdata <= '0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) predict_writes(cur_req);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() >= CALM_ITEMS && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(0, 5);
          in_tvalid <= 1'b0;
        end else begin
          cur_req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_req.op;
          in_tdata <= {{(TDATA_W - AW - DW){1'b0}}, cur_req.val, cur_req.idx};
        end
      end
    end
  end

  // write monitor
  int stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready)
        check_write(out_tdata[AW-1:0], out_tdata[AW+DW-1:AW], out_tlast);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (pending_reqs.size() >= CALM_ITEMS && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic queue_req(input opcode_t op, input logic [AW-1:0] idx,
                           input logic [DW-1:0] val);
    req_t r;
    r.op = op;
    r.idx = idx;
    r.val = val;
    pending_reqs.push_back(r);
    if (idx == REG_PH0) gen_hi[0] = val;
    if (idx == REG_PH1) gen_hi[1] = val;
  endtask

  initial begin
    int useful;
    int pick;
    int ch;
    logic [AW-1:0] hi_reg;
    logic [DW-1:0] cur;
    logic [DW-1:0] nxt;
    logic [2:0] lo;
    opcode_t op;

    foreach (chip_regs[i]) chip_regs[i] = '0;
    gen_hi[0] = '0;
    gen_hi[1] = '0;

    // directed part
    queue_req(OP_IF_CHANGED, REG_PH0, 8'h00);
    queue_req(OP_FORCED, REG_PH0, 8'h00);
    queue_req(OP_FORCED, 5'h02, 8'hA5);
    queue_req(OP_IF_CHANGED, REG_PH0, 8'h01);
    queue_req(OP_IF_CHANGED, REG_PH0, 8'h00);
    queue_req(OP_IF_CHANGED, REG_PH0, 8'hF8);
    queue_req(OP_IF_CHANGED, REG_PH0, 8'hFB);
    queue_req(OP_FORCED, REG_PH0, 8'hFC);
    queue_req(OP_IF_CHANGED, REG_PH0, 8'hFD);
    queue_req(OP_FORCED, 5'h06, 8'h5A);
    queue_req(OP_IF_CHANGED, REG_PH1, 8'h07);
    queue_req(OP_IF_CHANGED, REG_PH1, 8'h06);
    queue_req(OP_IF_CHANGED, REG_PH1, 8'hFF);
    queue_req(OP_IF_CHANGED, REG_PH1, 8'hFF);
    queue_req(OP_IF_CHANGED, 5'h01, 8'h0F);
    queue_req(OP_IF_CHANGED, FRAME_REG, 8'hC0);
    queue_req(OP_IF_CHANGED, FRAME_REG, 8'hFF);
    queue_req(OP_FORCED, FRAME_REG, 8'h00);
    queue_req(OP_IF_CHANGED, 5'h00, 8'hFF);
    queue_req(OP_FORCED, 5'h00, 8'hFF);
    queue_req(OP_IF_CHANGED, 5'h18, 8'h55);
    queue_req(OP_FORCED, 5'h1F, 8'hAA);
    queue_req(OP_IF_CHANGED, 5'h10, 8'h80);

    // random part, weighted toward period steps on the two pulse channels
    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      ch = $urandom_range(0, 1);
      hi_reg = ch ? REG_PH1 : REG_PH0;
      cur = gen_hi[ch];
      op = ($urandom_range(0, 9) == 0) ? OP_FORCED : OP_IF_CHANGED;
      useful++;
      if (pick < 40) begin
        lo = cur[2:0];
        if (lo == 3'd0 || (lo != 3'd7 && $urandom_range(0, 1) == 1)) lo = lo + 3'd1;
        else lo = lo - 3'd1;
        nxt = $urandom_range(0, 1) ? {cur[7:3], lo} : {5'($urandom), lo};
        queue_req(op, hi_reg, nxt);
      end else if (pick < 50) begin
        if ($urandom_range(0, 1))
          nxt = {cur[7:3], 3'(cur[2:0] + 3'($urandom_range(2, 6)))};
        else
          nxt = {5'($urandom), cur[2:0]};
        queue_req(op, hi_reg, nxt);
      end else if (pick < 58) begin
        queue_req(OP_IF_CHANGED, hi_reg, cur);
      end else if (pick < 63) begin
        useful--;
        queue_req(op, 5'($urandom_range(MIRROR_DEPTH, 31)), 8'($urandom));
      end else if (pick < 75) begin
        queue_req(opcode_t'($urandom_range(0, 1)), ch ? 5'h06 : 5'h02, 8'($urandom));
      end else begin
        queue_req(opcode_t'($urandom_range(0, 1)), 5'($urandom_range(0, MIRROR_DEPTH - 1)),
                  8'($urandom));
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("requests accepted: %0d (%0d sweeps, %0d plain writes, %0d unchanged, %0d ignored)",
             accepted, sweeps, plain_writes, skipped, ignored);
    $display("writes checked: %0d, mismatches: %0d, unexpected: %0d",
             writes_checked, mismatches, unexpected);
    if (mismatches == 0 && unexpected == 0 && expected_writes.size() == 0) begin
      $display("shadowed_register_write_sequencer_tb passed");
    end else begin
      $display("shadowed_register_write_sequencer_tb failed");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d writes still expected",
             cycle_count, expected_writes.size());
    $display("shadowed_register_write_sequencer_tb failed");
    $finish;
  end

endmodule
